>>> hdl/ssvg_pkg.sv
// ----------------------------------------------------------------------------
// ssvg_pkg - shared constants for the seeded step value generator
// Holds the hash constants, draw width, mode codes and default value format.
// ----------------------------------------------------------------------------
package ssvg_pkg;

   // Default fraction bits of the unsigned Q1.F value format
   localparam int unsigned VALUE_FRAC_BITS_DEF = 16;

   // Width of one uniform draw taken from the top of the hash
   localparam int unsigned DRAW_BITS = 24;

   // splitmix64 finaliser constants
   localparam logic [63:0] MIX_ADD  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MUL1 = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL2 = 64'h94D0_49BB_1331_11EB;

   // Step mode codes; the unused code behaves as base
   localparam logic [1:0] MODE_BASE      = 2'd0;
   localparam logic [1:0] MODE_EXPLICIT  = 2'd1;
   localparam logic [1:0] MODE_GENERATED = 2'd2;

endpackage

>>> hdl/ssvg_req_if.sv
// ----------------------------------------------------------------------------
// ssvg_req_if - request channel of the seeded step value generator
// One item asks for the target of one parameter on one step.
// ----------------------------------------------------------------------------
interface ssvg_req_if #(
   parameter int unsigned VALUE_FRAC_BITS = ssvg_pkg::VALUE_FRAC_BITS_DEF
);
   localparam int unsigned VW = VALUE_FRAC_BITS + 1;

   logic          valid;
   logic          ready;
   logic [1:0]    step_mode;
   logic [31:0]   step_seed;
   logic [VW-1:0] density;
   logic [15:0]   param_index;
   logic [VW-1:0] range_min;
   logic [VW-1:0] range_max;
   logic [VW-1:0] probability;
   logic          is_locked;
   logic          is_structural;
   logic          has_explicit;
   logic [VW-1:0] explicit_value;

   modport source (
      output valid, step_mode, step_seed, density, param_index, range_min, range_max,
             probability, is_locked, is_structural, has_explicit, explicit_value,
      input  ready
   );

   modport sink (
      input  valid, step_mode, step_seed, density, param_index, range_min, range_max,
             probability, is_locked, is_structural, has_explicit, explicit_value,
      output ready
   );

endinterface

>>> hdl/ssvg_rsp_if.sv
// ----------------------------------------------------------------------------
// ssvg_rsp_if - result channel of the seeded step value generator
// One item carries the target flag and the target value of one parameter.
// ----------------------------------------------------------------------------
interface ssvg_rsp_if #(
   parameter int unsigned VALUE_FRAC_BITS = ssvg_pkg::VALUE_FRAC_BITS_DEF
);
   localparam int unsigned VW = VALUE_FRAC_BITS + 1;

   logic          valid;
   logic          ready;
   logic          has_target;
   logic [VW-1:0] target_value;

   modport source (
      output valid, has_target, target_value,
      input  ready
   );

   modport sink (
      input  valid, has_target, target_value,
      output ready
   );

endinterface

>>> hdl/seeded_step_value_generator_core.sv
// ----------------------------------------------------------------------------
// seeded_step_value_generator_core - per-parameter step target generator
// Seven-stage pipeline: hashed gate and range draw in unsigned Q1.F fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Present one item per parameter on req_ch (valid/ready); an item is taken
//   at a rising edge with valid and ready both high. Each item gives exactly
//   one item on rsp_ch: has_target and target_value (zero without a target).
//   An item passes through the stage registers in order and leaves from the output
//   register; rsp_ch.valid is the valid bit of that output register.
//   Throughput: one item per cycle while the output is not stalled; the
//   two 64-bit multiplies of the hash lanes, each cut into a partial-product
//   stage and a sum stage, set the pipeline depth.
//   Stall: while the result in the output register is not taken, the whole
//   pipeline holds and req_ch.ready drops; nothing is lost or repeated.
//   Reset: synchronous, active high; clears all valid bits, so the pipeline
//   comes up empty and ready. There is no configuration and no other state.
// ----------------------------------------------------------------------------
module seeded_step_value_generator_core #(
   parameter int unsigned VALUE_FRAC_BITS = ssvg_pkg::VALUE_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ssvg_req_if.sink   req_ch,
   ssvg_rsp_if.source rsp_ch
);
   import ssvg_pkg::*;

   localparam int unsigned F      = VALUE_FRAC_BITS;
   localparam int unsigned VW     = F + 1;
   localparam int unsigned WW     = 2 * F + 4;              // width * density, signed
   localparam int unsigned PW     = 2 * VW;                 // probability * density
   localparam int unsigned LW     = 2 * F + 5;              // lower bound, signed
   localparam int unsigned GWW    = DRAW_BITS + 1 + WW;     // draw * width, signed
   localparam int unsigned TW     = 2 * F + DRAW_BITS + 6;  // full sum, signed
   localparam int unsigned RW     = TW - F - DRAW_BITS;     // result before clamp
   localparam int unsigned CW     = 2 * VW + DRAW_BITS;     // gate compare width
   localparam int unsigned G_SH   = (2 * F >= DRAW_BITS) ? 2 * F - DRAW_BITS : 0;
   localparam int unsigned P_SH   = (DRAW_BITS > 2 * F) ? DRAW_BITS - 2 * F : 0;
   localparam int unsigned STAGES = 7;
   localparam logic [VW-1:0] VONE = VW'(1) << F;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_PASS,
      KIND_GEN
   } kind_type;

   typedef struct packed {
      kind_type      kind;
      logic [VW-1:0] expv;
   } ctl_type;

   logic                 advance;
   logic [STAGES-1:0]    valid_ff, valid_in;

   ctl_type              c1_ff, c1_in, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, c6_in;
   logic [VW-1:0]        d1_ff, d1_in, rmin1_ff, rmax1_ff, prob1_ff;
   logic signed [VW:0]   diff2;
   logic signed [WW-1:0] w2_ff, w2_in, w3_ff, w4_ff, w5_ff;
   logic [PW-1:0]        p2_ff, p2_in, p3_ff, p4_ff, p5_ff;
   logic [VW:0]          sum2_ff, sum2_in;
   logic signed [LW-1:0] l3_ff, l3_in, l4_ff, l5_ff;
   logic signed [GWW-1:0] gw6_ff, gw6_in;
   logic signed [TW-1:0] lt6_ff, lt6_in, t7;
   logic signed [RW-1:0] r7;
   logic [CW-1:0]        gate_lhs, gate_rhs;
   logic                 gate_fail;
   logic                 has_ff, has_in;
   logic [VW-1:0]        val_ff, val_in;
   logic [63:0]          key0, key1;
   logic [DRAW_BITS-1:0] g0, g1;

   // Hold everything while the output item waits
   assign advance      = !valid_ff[STAGES-1] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign valid_in     = {valid_ff[STAGES-2:0], req_ch.valid};

   // Hash keys: seed, index at bit 32, salt at bit 48
   assign key0 = {15'd0, 1'b0, req_ch.param_index, req_ch.step_seed};
   assign key1 = {15'd0, 1'b1, req_ch.param_index, req_ch.step_seed};

   ssvg_mix64 u_mix_range (
      .clock  (clock),
      .enable (advance),
      .key    (key0),
      .draw   (g0)
   );

   ssvg_mix64 u_mix_gate (
      .clock  (clock),
      .enable (advance),
      .key    (key1),
      .draw   (g1)
   );

   always_comb begin
      // Stage 1: decide the kind of answer, clamp density
      c1_in.expv = req_ch.explicit_value;
      c1_in.kind = KIND_NONE;
      if (!req_ch.is_structural) begin
         case (req_ch.step_mode)
            MODE_EXPLICIT: begin
               if (req_ch.has_explicit) c1_in.kind = KIND_PASS;
            end
            MODE_GENERATED: begin
               if (req_ch.has_explicit)    c1_in.kind = KIND_PASS;
               else if (!req_ch.is_locked) c1_in.kind = KIND_GEN;
            end
            default: c1_in.kind = KIND_NONE;
         endcase
      end
      d1_in = (req_ch.density > VONE) ? VONE : req_ch.density;

      // Stage 2: range width scaled by density, gate threshold
      diff2   = $signed({1'b0, rmax1_ff}) - $signed({1'b0, rmin1_ff});
      w2_in   = $signed({1'b0, d1_ff}) * diff2;
      p2_in   = prob1_ff * d1_ff;
      sum2_in = {1'b0, rmin1_ff} + {1'b0, rmax1_ff};

      // Stage 3: lower bound of the shrunk range, scaled by 2^(F+1)
      l3_in = $signed({{(LW - VW - 1 - F){1'b0}}, sum2_ff, {F{1'b0}}}) - LW'(w2_ff);

      // Stage 6: gate against probability * density, draw * width
      gate_lhs  = CW'(g1) << G_SH;
      gate_rhs  = CW'(p5_ff) << P_SH;
      gate_fail = gate_lhs > gate_rhs;
      c6_in     = c5_ff;
      if (c5_ff.kind == KIND_GEN && gate_fail) c6_in.kind = KIND_NONE;
      gw6_in = $signed({1'b0, g0}) * w5_ff;
      lt6_in = TW'(l5_ff) <<< (DRAW_BITS - 1);

      // Stage 7: exact sum, floor, clamp to [0,1]
      t7 = lt6_ff + TW'(gw6_ff);
      r7 = RW'(t7 >>> (F + DRAW_BITS));
      case (c6_ff.kind)
         KIND_PASS: begin
            has_in = 1'b1;
            val_in = c6_ff.expv;
         end
         KIND_GEN: begin
            has_in = 1'b1;
            if (r7[RW-1])                     val_in = '0;
            else if ($unsigned(r7) > RW'(VONE)) val_in = VONE;
            else                              val_in = r7[VW-1:0];
         end
         default: begin
            has_in = 1'b0;
            val_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff    <= c1_in;
         d1_ff    <= d1_in;
         rmin1_ff <= req_ch.range_min;
         rmax1_ff <= req_ch.range_max;
         prob1_ff <= req_ch.probability;

         c2_ff    <= c1_ff;
         w2_ff    <= w2_in;
         p2_ff    <= p2_in;
         sum2_ff  <= sum2_in;

         c3_ff    <= c2_ff;
         w3_ff    <= w2_ff;
         p3_ff    <= p2_ff;
         l3_ff    <= l3_in;

         // wait for the hash lanes
         c4_ff    <= c3_ff;
         w4_ff    <= w3_ff;
         p4_ff    <= p3_ff;
         l4_ff    <= l3_ff;

         c5_ff    <= c4_ff;
         w5_ff    <= w4_ff;
         p5_ff    <= p4_ff;
         l5_ff    <= l4_ff;

         c6_ff    <= c6_in;
         gw6_ff   <= gw6_in;
         lt6_ff   <= lt6_in;

         has_ff   <= has_in;
         val_ff   <= val_in;
      end
   end

   assign rsp_ch.valid        = valid_ff[STAGES-1];
   assign rsp_ch.has_target   = has_ff;
   assign rsp_ch.target_value = val_ff;

endmodule

>>> hdl/ssvg_mix64.sv
// ----------------------------------------------------------------------------
// ssvg_mix64 - five-stage splitmix64 finaliser lane
// Each 64-bit multiply is split into 32x32 partial products, then summed.
// ----------------------------------------------------------------------------
module ssvg_mix64 (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [63:0]                    key,
   output logic [ssvg_pkg::DRAW_BITS-1:0] draw
);
   import ssvg_pkg::*;

   localparam int unsigned SHIFT_A = 30;
   localparam int unsigned SHIFT_B = 27;
   localparam int unsigned SHIFT_C = 31;

   logic [63:0] x1_ff, x1_in;
   logic [63:0] ll2_ff, ll2_in;
   logic [31:0] lh2_ff, lh2_in, hl2_ff, hl2_in;
   logic [63:0] m3_ff, m3_in;
   logic [63:0] ll4_ff, ll4_in;
   logic [31:0] lh4_ff, lh4_in, hl4_ff, hl4_in;
   logic [63:0] m5_ff, m5_in;
   logic [63:0] y2, y4, h5;

   always_comb begin
      x1_in  = key + MIX_ADD;

      // first multiply: partial products modulo 2^64
      y2     = x1_ff ^ (x1_ff >> SHIFT_A);
      ll2_in = 64'(y2[31:0]) * 64'(MIX_MUL1[31:0]);
      lh2_in = y2[31:0] * MIX_MUL1[63:32];
      hl2_in = y2[63:32] * MIX_MUL1[31:0];
      m3_in  = ll2_ff + {lh2_ff + hl2_ff, 32'd0};

      // second multiply
      y4     = m3_ff ^ (m3_ff >> SHIFT_B);
      ll4_in = 64'(y4[31:0]) * 64'(MIX_MUL2[31:0]);
      lh4_in = y4[31:0] * MIX_MUL2[63:32];
      hl4_in = y4[63:32] * MIX_MUL2[31:0];
      m5_in  = ll4_ff + {lh4_ff + hl4_ff, 32'd0};

      h5     = m5_ff ^ (m5_ff >> SHIFT_C);
      draw   = h5[63 -: DRAW_BITS];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff  <= x1_in;
         ll2_ff <= ll2_in;
         lh2_ff <= lh2_in;
         hl2_ff <= hl2_in;
         m3_ff  <= m3_in;
         ll4_ff <= ll4_in;
         lh4_ff <= lh4_in;
         hl4_ff <= hl4_in;
         m5_ff  <= m5_in;
      end
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for seeded_step_value_generator_core
// Feeds parameter requests through the request channel with random gaps and
// back-pressure, predicts each step target with an independent hash and
// fixed-point model, and checks every result item field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

   import ssvg_pkg::*;

   localparam int unsigned FRAC = VALUE_FRAC_BITS_DEF;
   localparam int unsigned VW   = FRAC + 1;
   localparam longint      VALUE_ONE = longint'(1) << FRAC;
   localparam logic [VW-1:0] VMAX   = {VW{1'b1}};
   localparam logic [VW-1:0] ONE_Q  = VW'(VALUE_ONE);
   // The spare mode code: the block must treat it as base
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1000;

   // One request as the sender holds it; drain_first holds the item back
   // until every outstanding result has come out of the block.
   typedef struct {
      logic [1:0]    mode;
      logic [31:0]   seed;
      logic [VW-1:0] density;
      logic [15:0]   index;
      logic [VW-1:0] range_min;
      logic [VW-1:0] range_max;
      logic [VW-1:0] probability;
      logic          locked;
      logic          structural;
      logic          has_explicit;
      logic [VW-1:0] explicit_value;
      bit            drain_first;
   } step_request_type;

   typedef struct {
      logic          has_target;
      logic [VW-1:0] target_value;
   } step_target_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssvg_req_if #(.VALUE_FRAC_BITS(FRAC)) req_ch ();
   ssvg_rsp_if #(.VALUE_FRAC_BITS(FRAC)) rsp_ch ();

   seeded_step_value_generator_core #(.VALUE_FRAC_BITS(FRAC)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   step_request_type request_queue[$];   // items still to be offered
   step_target_type  target_queue[$];    // targets owed by the block, oldest first
   int unsigned   request_total = 0;
   int unsigned   taken_count   = 0;
   int unsigned   fail_count    = 0;
   bit            item_taken    = 1'b0;
   bit            quiet         = 1'b0;
   int unsigned   send_gap      = 0;
   int unsigned   recv_gap      = 0;
   step_request_type next_req;
   step_request_type seen_req;
   step_target_type  want;

   // Two-phase clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // splitmix64 finaliser, 64-bit wrap-around arithmetic
   function automatic logic [63:0] splitmix_finalise(logic [63:0] x);
      x = x + MIX_ADD;
      x = (x ^ (x >> 30)) * MIX_MUL1;
      x = (x ^ (x >> 27)) * MIX_MUL2;
      return x ^ (x >> 31);
   endfunction

   // 24-bit uniform draw: key holds seed low, index above it, salt at bit 48
   function automatic logic [DRAW_BITS-1:0] hash_draw(logic [31:0] seed, logic [15:0] index,
                                                      logic salt);
      logic [63:0] mixed;
      mixed = splitmix_finalise({15'd0, salt, index, seed});
      return mixed[63:64-DRAW_BITS];
   endfunction

   // Target of one parameter on one step.
   // The placed value is floor((lower * 2^23 + g0 * spread) / 2^40), where
   // lower = (min + max) * one - spread is twice the low end of the window
   // in Q.32, and spread = density * (max - min); all exact in 64 bits.
   function automatic step_target_type step_target(step_request_type q);
      step_target_type   t;
      longint unsigned   dens_c;
      longint unsigned   gate_draw;
      longint unsigned   place_draw;
      longint unsigned   gate_level;
      longint            spread;
      longint            lower;
      longint            numer;
      longint            placed;
      t.has_target   = 1'b0;
      t.target_value = '0;
      if (!q.structural) begin
         if (q.mode == MODE_EXPLICIT) begin
            if (q.has_explicit) begin
               t.has_target   = 1'b1;
               t.target_value = q.explicit_value;
            end
         end else if (q.mode == MODE_GENERATED) begin
            if (q.has_explicit) begin
               t.has_target   = 1'b1;
               t.target_value = q.explicit_value;
            end else if (!q.locked) begin
               dens_c     = (longint'(q.density) > VALUE_ONE) ? VALUE_ONE : longint'(q.density);
               gate_draw  = hash_draw(q.seed, q.index, 1'b1);
               gate_level = longint'(q.probability) * dens_c;
               // gate passes when draw / 2^24 <= prob * density / 2^32
               if ((gate_draw << (2 * FRAC)) <= (gate_level << DRAW_BITS)) begin
                  place_draw = hash_draw(q.seed, q.index, 1'b0);
                  spread = longint'(dens_c) * (longint'(q.range_max) - longint'(q.range_min));
                  lower  = (longint'(q.range_min) + longint'(q.range_max)) * VALUE_ONE - spread;
                  numer  = (lower <<< (DRAW_BITS - 1)) + longint'(place_draw) * spread;
                  placed = numer >>> (FRAC + DRAW_BITS);
                  if (placed < 0)
                     placed = 0;
                  if (placed > VALUE_ONE)
                     placed = VALUE_ONE;
                  t.has_target   = 1'b1;
                  t.target_value = placed[VW-1:0];
               end
            end
         end
      end
      return t;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Full-range request with a sure gate; callers adjust what they test
   function automatic step_request_type plain_request(logic [1:0] mode);
      step_request_type r;
      r.mode           = mode;
      r.seed           = $urandom;
      r.density        = ONE_Q;
      r.index          = 16'($urandom_range(0, 65535));
      r.range_min      = '0;
      r.range_max      = ONE_Q;
      r.probability    = ONE_Q;
      r.locked         = 1'b0;
      r.structural     = 1'b0;
      r.has_explicit   = 1'b0;
      r.explicit_value = '0;
      r.drain_first    = 1'b0;
      return r;
   endfunction

   // Mostly well-formed generated requests with random content; the rest
   // is noise across every field, the spare mode and out-of-range values.
   function automatic step_request_type random_request();
      step_request_type r;
      logic [VW-1:0] a;
      logic [VW-1:0] b;
      r = plain_request(MODE_GENERATED);
      if ($urandom_range(0, 99) < 85) begin
         a = VW'($urandom_range(0, 65536));
         b = VW'($urandom_range(0, 65536));
         // keep min <= max, but swap now and then
         if ((a > b) != ($urandom_range(0, 7) == 0)) begin
            r.range_min = b;
            r.range_max = a;
         end else begin
            r.range_min = a;
            r.range_max = b;
         end
         r.density     = VW'($urandom_range(0, 65536));
         r.probability = ($urandom_range(0, 3) == 0) ? VW'($urandom_range(0, 65536))
                                                     : VW'($urandom_range(32768, 65536));
      end else begin
         r.mode           = 2'($urandom_range(0, 3));
         r.density        = VW'($urandom_range(0, 131071));
         r.range_min      = VW'($urandom_range(0, 131071));
         r.range_max      = VW'($urandom_range(0, 131071));
         r.probability    = VW'($urandom_range(0, 131071));
         r.locked         = 1'($urandom_range(0, 1));
         r.structural     = 1'($urandom_range(0, 1));
         r.has_explicit   = 1'($urandom_range(0, 1));
         r.explicit_value = VW'($urandom_range(0, 131071));
      end
      return r;
   endfunction

   // Print one line per mismatch and count it
   task automatic report_mismatch(string msg);
      fail_count++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Driver: change inputs at the falling edge only
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         // no idling near the end, and in one stretch out of every four
         quiet = (request_queue.size() < 120) || ((request_queue.size() / 100) % 4 == 1);

         // request side: offer the next item once the current one is taken
         if (item_taken || !req_ch.valid) begin
            item_taken = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (request_queue.size() != 0 &&
                         !(request_queue[0].drain_first && target_queue.size() != 0)) begin
               next_req = request_queue.pop_front();
               req_ch.step_mode      <= next_req.mode;
               req_ch.step_seed      <= next_req.seed;
               req_ch.density        <= next_req.density;
               req_ch.param_index    <= next_req.index;
               req_ch.range_min      <= next_req.range_min;
               req_ch.range_max      <= next_req.range_max;
               req_ch.probability    <= next_req.probability;
               req_ch.is_locked      <= next_req.locked;
               req_ch.is_structural  <= next_req.structural;
               req_ch.has_explicit   <= next_req.has_explicit;
               req_ch.explicit_value <= next_req.explicit_value;
               req_ch.valid          <= 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 9);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end

         // result side: stall in bursts
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0)
               recv_gap = $urandom_range(1, 9);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge; check results
   // before recording new requests so the queue order never depends on
   // process order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (target_queue.size() == 0) begin
               report_mismatch("result item with no request outstanding");
            end else begin
               want = target_queue.pop_front();
               if (rsp_ch.has_target !== want.has_target)
                  report_mismatch($sformatf("has_target got %b want %b",
                                            rsp_ch.has_target, want.has_target));
               if (rsp_ch.target_value !== want.target_value)
                  report_mismatch($sformatf("target_value got 0x%05h want 0x%05h",
                                            rsp_ch.target_value, want.target_value));
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            seen_req.mode           = req_ch.step_mode;
            seen_req.seed           = req_ch.step_seed;
            seen_req.density        = req_ch.density;
            seen_req.index          = req_ch.param_index;
            seen_req.range_min      = req_ch.range_min;
            seen_req.range_max      = req_ch.range_max;
            seen_req.probability    = req_ch.probability;
            seen_req.locked         = req_ch.is_locked;
            seen_req.structural     = req_ch.is_structural;
            seen_req.has_explicit   = req_ch.has_explicit;
            seen_req.explicit_value = req_ch.explicit_value;
            seen_req.drain_first    = 1'b0;
            target_queue.push_back(step_target(seen_req));
            item_taken = 1'b1;
            taken_count++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      step_request_type r;

      // hold every input at a known value from time zero
      req_ch.valid          = 1'b0;
      req_ch.step_mode      = MODE_BASE;
      req_ch.step_seed      = '0;
      req_ch.density        = '0;
      req_ch.param_index    = '0;
      req_ch.range_min      = '0;
      req_ch.range_max      = '0;
      req_ch.probability    = '0;
      req_ch.is_locked      = 1'b0;
      req_ch.is_structural  = 1'b0;
      req_ch.has_explicit   = 1'b0;
      req_ch.explicit_value = '0;
      rsp_ch.ready          = 1'b0;

      // Directed part
      // base mode: never a target, even with a posed value
      r = plain_request(MODE_BASE);
      request_queue.push_back(r);
      r.has_explicit = 1'b1; r.explicit_value = VW'(12345);
      request_queue.push_back(r);
      // explicit mode: pass the posed value through, top and bottom
      r = plain_request(MODE_EXPLICIT); r.has_explicit = 1'b1; r.explicit_value = ONE_Q;
      request_queue.push_back(r);
      r.explicit_value = '0;
      request_queue.push_back(r);
      // explicit value above one passes unchanged
      r.explicit_value = VMAX;
      request_queue.push_back(r);
      // explicit mode without a value
      r.has_explicit = 1'b0;
      request_queue.push_back(r);
      // structural parameter in explicit mode
      r.has_explicit = 1'b1; r.structural = 1'b1;
      request_queue.push_back(r);
      // spare mode code behaves as base
      r = plain_request(MODE_SPARE); r.has_explicit = 1'b1; r.explicit_value = VW'(777);
      request_queue.push_back(r);
      // generated: posed value wins, even over the lock
      r = plain_request(MODE_GENERATED); r.has_explicit = 1'b1; r.locked = 1'b1;
      r.explicit_value = VW'(40000);
      request_queue.push_back(r);
      // generated, locked, no posed value
      r.has_explicit = 1'b0;
      request_queue.push_back(r);
      // generated, structural
      r.locked = 1'b0; r.structural = 1'b1;
      request_queue.push_back(r);
      // sure gate at the seed and index extremes
      r = plain_request(MODE_GENERATED); r.seed = '0; r.index = '0;
      request_queue.push_back(r);
      r.seed = '1; r.index = '1;
      request_queue.push_back(r);
      // zero probability and zero density close the gate
      r = plain_request(MODE_GENERATED); r.probability = '0;
      request_queue.push_back(r);
      r = plain_request(MODE_GENERATED); r.density = '0;
      request_queue.push_back(r);
      // density above one is clamped in gate and range
      r = plain_request(MODE_GENERATED); r.density = VMAX; r.range_min = VW'(10000);
      r.range_max = VW'(50000);
      request_queue.push_back(r);
      // probability above one used as given
      r = plain_request(MODE_GENERATED); r.probability = VMAX; r.density = VW'(40000);
      request_queue.push_back(r);
      // maximum below minimum, signed range arithmetic then clamp
      r = plain_request(MODE_GENERATED); r.range_min = VW'(60000); r.range_max = VW'(1000);
      request_queue.push_back(r);
      r = plain_request(MODE_GENERATED); r.range_min = VMAX; r.range_max = '0;
      r.density = VW'(3);
      request_queue.push_back(r);
      // degenerate ranges at zero, one, and beyond one
      r = plain_request(MODE_GENERATED); r.range_min = '0; r.range_max = '0;
      request_queue.push_back(r);
      r.range_min = ONE_Q; r.range_max = ONE_Q;
      request_queue.push_back(r);
      r.range_min = VMAX; r.range_max = VMAX;
      request_queue.push_back(r);
      // tiny density with maximal probability: narrow window at the centre
      r = plain_request(MODE_GENERATED); r.density = VW'(1); r.probability = VMAX;
      r.range_min = VW'(100); r.range_max = VW'(65000);
      request_queue.push_back(r);

      // Random part; hold back twice until the block has drained
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         r = random_request();
         r.drain_first = (n == 0) || (n == RANDOM_ITEMS / 2);
         request_queue.push_back(r);
      end
      request_total = request_queue.size();

      // reset held from the start, released at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every item to be taken and every result to be checked
      while (taken_count < request_total || target_queue.size() != 0)
         @(negedge clock);
      // let any stray result show itself
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("seeded_step_value_generator_core verification clean");
      end else begin
         $display("seeded_step_value_generator_core verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #400000;
      $display("seeded_step_value_generator_core verification failed");
      $finish;
   end

endmodule
